[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the mismatch filter checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, switched off while reset is high.
`define PDMF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Checked on every rising clock edge, reset included.
`define PDMF_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) \
      else $error(msg);

`endif

[rtl/pdmf_pkg.sv]
// ----------------------------------------------------------------------------
// pdmf_pkg
// Widths, constants, types and chunk helpers of the packed DNA mismatch filter.
// ----------------------------------------------------------------------------
package pdmf_pkg;

   // Field widths
   localparam int ALEN_W  = 11;
   localparam int NB_W    = 5;
   localparam int WORD_W  = 32;
   localparam int OFF_W   = 4;
   localparam int SIM_W   = 17;
   localparam int MM_W    = 5;
   localparam int PROD_W  = SIM_W + ALEN_W;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_SIMILARITY = 1'b0;   // register index, paddr[2]

   // Constants
   localparam logic [ALEN_W-1:0] MAX_ALIGN_LEN   = 11'd1024;
   localparam logic [NB_W-1:0]   BASES_PER_CHUNK = 5'd16;
   localparam logic [SIM_W-1:0]  Q16_ONE         = 17'd65536;
   localparam logic [PROD_W-1:0] Q16_HALF        = 28'd32768;
   localparam logic [SIM_W-1:0]  SIM_RESET       = 17'd62259;

   // Result queue
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 3;

   typedef struct packed {
      logic [ALEN_W-1:0] match_count;
      logic              rejected;
   } rsp_item_type;

   // Align the chunk's first base to the top and clear bases past the chunk
   function automatic logic [WORD_W-1:0] extract_chunk(
      input logic [WORD_W-1:0] lo,
      input logic [WORD_W-1:0] hi,
      input logic [OFF_W-1:0]  off,
      input logic [NB_W-1:0]   nb
   );
      logic [2*WORD_W-1:0] shifted;
      logic [WORD_W-1:0]   mask;
      shifted = {lo, hi} << {off, 1'b0};
      mask    = ~({WORD_W{1'b1}} >> {nb, 1'b0});
      return shifted[2*WORD_W-1:WORD_W] & mask;
   endfunction

   // Reverse-complement the top nb bases, result left-aligned
   function automatic logic [WORD_W-1:0] rev_comp(
      input logic [WORD_W-1:0] w,
      input logic [NB_W-1:0]   nb
   );
      logic [WORD_W-1:0] c;
      logic [WORD_W-1:0] r;
      logic [NB_W-1:0]   pad;
      c   = ~w;
      pad = BASES_PER_CHUNK - nb;
      for (int i = 0; i < 16; i++) begin
         r[2*(15-i) +: 2] = c[2*i +: 2];
      end
      return r << {pad, 1'b0};
   endfunction

   // Number of differing 2-bit bases
   function automatic logic [MM_W-1:0] count_mismatch(
      input logic [WORD_W-1:0] x,
      input logic [WORD_W-1:0] y
   );
      logic [WORD_W-1:0] d;
      logic [MM_W-1:0]   n;
      d = x ^ y;
      n = '0;
      for (int i = 0; i < 16; i++) begin
         n = n + MM_W'(d[2*i] | d[2*i+1]);
      end
      return n;
   endfunction

endpackage

[rtl/pdmf_if.sv]
// ----------------------------------------------------------------------------
// pdmf_req_if / pdmf_rsp_if
// Valid/ready channels carrying chunk items in and result items out.
// ----------------------------------------------------------------------------

// Chunk item channel
interface pdmf_req_if;
   logic                            valid;
   logic                            ready;
   logic                            first_chunk;
   logic                            last_chunk;
   logic [pdmf_pkg::ALEN_W-1:0]     align_length;
   logic [pdmf_pkg::NB_W-1:0]       chunk_bases;
   logic [pdmf_pkg::WORD_W-1:0]     query_word_lo;
   logic [pdmf_pkg::WORD_W-1:0]     query_word_hi;
   logic [pdmf_pkg::OFF_W-1:0]      query_offset;
   logic [pdmf_pkg::WORD_W-1:0]     ref_word_lo;
   logic [pdmf_pkg::WORD_W-1:0]     ref_word_hi;
   logic [pdmf_pkg::OFF_W-1:0]      ref_offset;
   logic                            strand;

   modport source (
      output valid, first_chunk, last_chunk, align_length, chunk_bases,
             query_word_lo, query_word_hi, query_offset,
             ref_word_lo, ref_word_hi, ref_offset, strand,
      input  ready
   );
   modport sink (
      input  valid, first_chunk, last_chunk, align_length, chunk_bases,
             query_word_lo, query_word_hi, query_offset,
             ref_word_lo, ref_word_hi, ref_offset, strand,
      output ready
   );
endinterface

// Result item channel
interface pdmf_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [pdmf_pkg::ALEN_W-1:0]     match_count;
   logic                            rejected;

   modport source (
      output valid, match_count, rejected,
      input  ready
   );
   modport sink (
      input  valid, match_count, rejected,
      output ready
   );
endinterface

[rtl/packed_dna_mismatch_filter.sv]
// ----------------------------------------------------------------------------
// packed_dna_mismatch_filter
// Compares 16-base packed DNA chunks, tracks the running match count of an
// alignment and rejects it once the count drops below the threshold.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake          carries
//   req_ch    in         valid/ready        one chunk of an alignment
//   rsp_ch    out        valid/ready        match count or rejection
//   psel ...  in         APB write/read     similarity register
//
// One item is accepted per cycle while req_ch.ready is high; a result passes
// through both stage registers and a 4-entry queue to rsp_ch. Stage 1
// aligns, masks and compares the chunk and forms the threshold product;
// stage 2 updates the running count. req_ch.ready drops only when the
// queue plus the two stages in flight could fill it. Synchronous active-high
// reset empties the pipeline and queue and restores similarity to 62259.
// ----------------------------------------------------------------------------
module packed_dna_mismatch_filter (
   input  logic                                clock,
   input  logic                                reset,
   pdmf_req_if.sink                            req_ch,
   pdmf_rsp_if.source                          rsp_ch,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [pdmf_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [pdmf_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [pdmf_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   // ---------------------------------------------------------------------
   // Configuration register
   // ---------------------------------------------------------------------
   logic [pdmf_pkg::SIM_W-1:0] similarity_ff;
   logic                       csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == pdmf_pkg::REG_SIMILARITY);

   always_ff @(posedge clock) begin
      if (reset) begin
         similarity_ff <= pdmf_pkg::SIM_RESET;
      end else if (csr_write) begin
         similarity_ff <= pwdata[pdmf_pkg::SIM_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == pdmf_pkg::REG_SIMILARITY) begin
         prdata = pdmf_pkg::CSR_DATA_W'(similarity_ff);
      end
   end

   // ---------------------------------------------------------------------
   // Input register (stage 1)
   // ---------------------------------------------------------------------
   logic                            s1_valid_ff;
   logic                            s1_first_ff;
   logic                            s1_last_ff;
   logic [pdmf_pkg::ALEN_W-1:0]     s1_alen_ff;
   logic [pdmf_pkg::NB_W-1:0]       s1_nb_ff;
   logic [pdmf_pkg::WORD_W-1:0]     s1_qlo_ff;
   logic [pdmf_pkg::WORD_W-1:0]     s1_qhi_ff;
   logic [pdmf_pkg::OFF_W-1:0]      s1_qoff_ff;
   logic [pdmf_pkg::WORD_W-1:0]     s1_rlo_ff;
   logic [pdmf_pkg::WORD_W-1:0]     s1_rhi_ff;
   logic [pdmf_pkg::OFF_W-1:0]      s1_roff_ff;
   logic                            s1_strand_ff;
   logic                            req_accept;

   assign req_accept = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_first_ff  <= req_ch.first_chunk;
         s1_last_ff   <= req_ch.last_chunk;
         s1_alen_ff   <= req_ch.align_length;
         s1_nb_ff     <= req_ch.chunk_bases;
         s1_qlo_ff    <= req_ch.query_word_lo;
         s1_qhi_ff    <= req_ch.query_word_hi;
         s1_qoff_ff   <= req_ch.query_offset;
         s1_rlo_ff    <= req_ch.ref_word_lo;
         s1_rhi_ff    <= req_ch.ref_word_hi;
         s1_roff_ff   <= req_ch.ref_offset;
         s1_strand_ff <= req_ch.strand;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1 logic: chunk compare and threshold
   // ---------------------------------------------------------------------
   logic [pdmf_pkg::NB_W-1:0]    nb_clamped;
   logic [pdmf_pkg::WORD_W-1:0]  query_chunk;
   logic [pdmf_pkg::WORD_W-1:0]  ref_chunk;
   logic [pdmf_pkg::WORD_W-1:0]  ref_oriented;
   logic [pdmf_pkg::MM_W-1:0]    mismatch_in;
   logic [pdmf_pkg::ALEN_W-1:0]  alen_in;
   logic [pdmf_pkg::SIM_W-1:0]   sim_clamped;
   logic [pdmf_pkg::PROD_W-1:0]  thr_sum;
   logic [pdmf_pkg::ALEN_W-1:0]  thr_in;

   always_comb begin
      nb_clamped   = (s1_nb_ff > pdmf_pkg::BASES_PER_CHUNK) ?
                     pdmf_pkg::BASES_PER_CHUNK : s1_nb_ff;
      query_chunk  = pdmf_pkg::extract_chunk(s1_qlo_ff, s1_qhi_ff, s1_qoff_ff, nb_clamped);
      ref_chunk    = pdmf_pkg::extract_chunk(s1_rlo_ff, s1_rhi_ff, s1_roff_ff, nb_clamped);
      ref_oriented = s1_strand_ff ? pdmf_pkg::rev_comp(ref_chunk, nb_clamped) : ref_chunk;
      mismatch_in  = pdmf_pkg::count_mismatch(query_chunk, ref_oriented);
   end

   // Rounded threshold: (sim * len + half) >> 16
   always_comb begin
      alen_in     = (s1_alen_ff > pdmf_pkg::MAX_ALIGN_LEN) ?
                    pdmf_pkg::MAX_ALIGN_LEN : s1_alen_ff;
      sim_clamped = (similarity_ff > pdmf_pkg::Q16_ONE) ? pdmf_pkg::Q16_ONE : similarity_ff;
      thr_sum     = (pdmf_pkg::PROD_W'(sim_clamped) * pdmf_pkg::PROD_W'(alen_in))
                    + pdmf_pkg::Q16_HALF;
      thr_in      = thr_sum[16 +: pdmf_pkg::ALEN_W];
   end

   // ---------------------------------------------------------------------
   // Stage 2 register
   // ---------------------------------------------------------------------
   logic                           s2_valid_ff;
   logic                           s2_first_ff;
   logic                           s2_last_ff;
   logic [pdmf_pkg::ALEN_W-1:0]    s2_alen_ff;
   logic [pdmf_pkg::ALEN_W-1:0]    s2_thr_ff;
   logic [pdmf_pkg::MM_W-1:0]      s2_mm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_first_ff <= s1_first_ff;
         s2_last_ff  <= s1_last_ff;
         s2_alen_ff  <= alen_in;
         s2_thr_ff   <= thr_in;
         s2_mm_ff    <= mismatch_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2 logic: running count, threshold check, result
   // ---------------------------------------------------------------------
   logic [pdmf_pkg::ALEN_W-1:0]  running_ff, running_in;
   logic [pdmf_pkg::ALEN_W-1:0]  threshold_ff, threshold_in;
   logic                         skipping_ff, skipping_in;
   logic [pdmf_pkg::ALEN_W-1:0]  cur_run;
   logic [pdmf_pkg::ALEN_W-1:0]  cur_thr;
   logic [pdmf_pkg::ALEN_W-1:0]  run_left;
   logic                         below;
   logic                         push;
   pdmf_pkg::rsp_item_type       push_item;

   always_comb begin
      cur_run      = s2_first_ff ? s2_alen_ff : running_ff;
      cur_thr      = s2_first_ff ? s2_thr_ff  : threshold_ff;
      below        = {1'b0, cur_run} <
                     ({1'b0, cur_thr} + (pdmf_pkg::ALEN_W+1)'(s2_mm_ff));
      run_left     = cur_run - pdmf_pkg::ALEN_W'(s2_mm_ff);
      running_in   = running_ff;
      threshold_in = threshold_ff;
      skipping_in  = skipping_ff;
      push         = 1'b0;
      push_item    = '0;
      if (s2_valid_ff && (s2_first_ff || !skipping_ff)) begin
         threshold_in = cur_thr;
         if (below) begin
            // reject now and drop the rest of the alignment
            running_in            = '0;
            skipping_in           = 1'b1;
            push                  = 1'b1;
            push_item.match_count = '0;
            push_item.rejected    = 1'b1;
         end else begin
            running_in  = run_left;
            skipping_in = s2_last_ff;
            if (s2_last_ff) begin
               push                  = 1'b1;
               push_item.match_count = run_left;
               push_item.rejected    = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= '0;
         threshold_ff <= '0;
         skipping_ff  <= 1'b0;
      end else begin
         running_ff   <= running_in;
         threshold_ff <= threshold_in;
         skipping_ff  <= skipping_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result queue
   // ---------------------------------------------------------------------
   pdmf_pkg::rsp_item_type         queue_ff [pdmf_pkg::RSP_DEPTH];
   logic [pdmf_pkg::RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pdmf_pkg::RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pdmf_pkg::RSP_CNT_W-1:0] count_ff, count_in;
   logic [pdmf_pkg::RSP_CNT_W-1:0] committed;
   logic                           pop;

   assign pop = rsp_ch.valid && rsp_ch.ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + pdmf_pkg::RSP_CNT_W'(push) - pdmf_pkg::RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= push_item;
      end
   end

   // Reserve a queue slot for every item still in the pipeline
   assign committed = count_ff + pdmf_pkg::RSP_CNT_W'(s1_valid_ff)
                      + pdmf_pkg::RSP_CNT_W'(s2_valid_ff);
   assign req_ch.ready = committed < pdmf_pkg::RSP_CNT_W'(pdmf_pkg::RSP_DEPTH);

   assign rsp_ch.valid       = count_ff != '0;
   assign rsp_ch.match_count = queue_ff[rd_ptr_ff].match_count;
   assign rsp_ch.rejected    = queue_ff[rd_ptr_ff].rejected;

endmodule

[rtl/pdmf_checker.sv]
// ----------------------------------------------------------------------------
// pdmf_checker
// Port-level checks of the mismatch filter, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pdmf_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [pdmf_pkg::ALEN_W-1:0]     rsp_match_count,
   input logic                            rsp_rejected
);

   // A waiting result holds until taken
   `PDMF_ASSERT(a_rsp_hold,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_match_count)
         && $stable(rsp_rejected),
      "result changed while stalled")

   // A rejected alignment reports no matches
   `PDMF_ASSERT(a_reject_zero, rsp_valid && rsp_rejected |-> rsp_match_count == '0,
      "rejected result with nonzero count")

   // Count never exceeds the longest alignment
   `PDMF_ASSERT(a_count_max, rsp_valid |-> rsp_match_count <= pdmf_pkg::MAX_ALIGN_LEN,
      "match count above limit")

   // Reset empties the result queue
   `PDMF_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result pending after reset")

   // A result queue that fills from empty was fed by an earlier accepted item
   `PDMF_ASSERT(a_rsp_latency,
      rsp_valid && !$past(rsp_valid) |-> $past(req_valid && req_ready, 3),
      "result without an accepted item")

endmodule

bind packed_dna_mismatch_filter pdmf_checker u_pdmf_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_match_count (rsp_ch.match_count),
   .rsp_rejected    (rsp_ch.rejected)
);

[sim/packed_dna_mismatch_filter_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// packed_dna_mismatch_filter_tb
// Self-checking bench for the packed DNA mismatch filter. Chunk items go in
// through bursty traffic, results come out against a stalling receiver, and
// an in-bench scoreboard recomputes every match count and rejection from the
// chunk contents, the running tally and the similarity register.
// ----------------------------------------------------------------------------
module packed_dna_mismatch_filter_tb;
   import pdmf_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;   // quiet cycles before giving up
   localparam int SETTLE_CYCLES  = 8;      // pipeline is two stages deep
   localparam int PHASE_ITEMS    = 250;    // chunk items per random phase
   localparam logic [CSR_ADDR_W-1:0] SIM_ADDR = {REG_SIMILARITY, 2'b00};

   typedef struct {
      logic              first_chunk;
      logic              last_chunk;
      logic [ALEN_W-1:0] align_length;
      logic [NB_W-1:0]   chunk_bases;
      logic [WORD_W-1:0] q_lo;
      logic [WORD_W-1:0] q_hi;
      logic [OFF_W-1:0]  q_off;
      logic [WORD_W-1:0] r_lo;
      logic [WORD_W-1:0] r_hi;
      logic [OFF_W-1:0]  r_off;
      logic              strand;
   } chunk_type;

   typedef enum int {RX_OPEN, RX_SPOTTY, RX_PERIODIC, RX_CHOKED} rx_mode_type;

   logic clock;
   logic reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   pdmf_req_if req_if ();
   pdmf_rsp_if rsp_if ();

   packed_dna_mismatch_filter DUT (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_if),
      .rsp_ch  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Scoreboard state
   logic [SIM_W-1:0]  sim_setting;
   logic [ALEN_W-1:0] match_tally;
   logic [ALEN_W-1:0] pass_mark;
   logic              dropping;
   rsp_item_type      pending_results[$];

   int mismatches;
   int items_sent;
   int live_items;
   int results_checked;
   int rejects_seen;
   int csr_writes;
   int burst_left;
   rx_mode_type rx_mode;
   int rx_left;
   int rx_tick;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $realtime);
      mismatches++;
   endtask

   // Expected behavior of one accepted chunk
   task automatic predict_chunk(input chunk_type c, output rsp_item_type res,
                                output bit has_res, output bit ignored);
      logic [SIM_W-1:0]  s;
      logic [ALEN_W-1:0] a;
      logic [2*WORD_W-1:0] qj;
      logic [2*WORD_W-1:0] rj;
      logic [1:0] qb;
      logic [1:0] rb;
      int n;
      int mm;
      int t;
      has_res = 1'b0;
      ignored = 1'b0;
      res     = '0;
      n = (c.chunk_bases > BASES_PER_CHUNK) ? int'(BASES_PER_CHUNK) : int'(c.chunk_bases);
      if (c.first_chunk) begin
         s = (sim_setting > Q16_ONE) ? Q16_ONE : sim_setting;
         a = (c.align_length > MAX_ALIGN_LEN) ? MAX_ALIGN_LEN : c.align_length;
         t = (int'(s) * int'(a) + 32768) >> 16;
         match_tally = a;
         pass_mark   = ALEN_W'(t);
         dropping    = 1'b0;
      end else if (dropping) begin
         ignored = 1'b1;
         return;
      end
      // base by base; the reverse strand reads the reference backwards, complemented
      qj = {c.q_lo, c.q_hi};
      rj = {c.r_lo, c.r_hi};
      mm = 0;
      for (int k = 0; k < n; k++) begin
         qb = qj[63 - 2*(int'(c.q_off) + k) -: 2];
         if (c.strand)
            rb = ~rj[63 - 2*(int'(c.r_off) + n - 1 - k) -: 2];
         else
            rb = rj[63 - 2*(int'(c.r_off) + k) -: 2];
         if (qb != rb) mm++;
      end
      if (int'(match_tally) < int'(pass_mark) + mm) begin
         match_tally = '0;
         dropping    = 1'b1;
         res.rejected = 1'b1;
         has_res = 1'b1;
      end else begin
         match_tally = match_tally - ALEN_W'(mm);
         if (c.last_chunk) begin
            dropping = 1'b1;
            res.match_count = match_tally;
            has_res = 1'b1;
         end
      end
   endtask

   function automatic chunk_type raw_chunk(
      input bit first_c, input bit last_c, input logic [ALEN_W-1:0] alen,
      input logic [NB_W-1:0] nb,
      input logic [WORD_W-1:0] qlo, input logic [WORD_W-1:0] qhi, input logic [OFF_W-1:0] qo,
      input logic [WORD_W-1:0] rlo, input logic [WORD_W-1:0] rhi, input logic [OFF_W-1:0] ro,
      input bit rc
   );
      chunk_type c;
      c.first_chunk  = first_c;
      c.last_chunk   = last_c;
      c.align_length = alen;
      c.chunk_bases  = nb;
      c.q_lo  = qlo;
      c.q_hi  = qhi;
      c.q_off = qo;
      c.r_lo  = rlo;
      c.r_hi  = rhi;
      c.r_off = ro;
      c.strand = rc;
      return c;
   endfunction

   // Chunk whose reference matches the read except for mutations (per mille),
   // placed at random offsets with random filler around it
   function automatic chunk_type make_chunk(input bit first_c, input bit last_c, input int alen,
                                            input int nb, input bit rc, input int mut_pm);
      logic [2*WORD_W-1:0] qj;
      logic [2*WORD_W-1:0] rj;
      logic [1:0] qb;
      logic [1:0] rb;
      int n;
      int qo;
      int ro;
      int pos;
      qj = {$urandom, $urandom};
      rj = {$urandom, $urandom};
      qo = $urandom_range(0, 15);
      ro = $urandom_range(0, 15);
      n  = (nb > 16) ? 16 : nb;
      for (int k = 0; k < n; k++) begin
         qb = 2'($urandom);
         rb = qb;
         if ($urandom_range(0, 999) < mut_pm) rb = qb ^ 2'($urandom_range(1, 3));
         pos = rc ? n - 1 - k : k;
         qj[63 - 2*(qo + k) -: 2]   = qb;
         rj[63 - 2*(ro + pos) -: 2] = rc ? ~rb : rb;
      end
      return raw_chunk(first_c, last_c, ALEN_W'(alen), NB_W'(nb), qj[63:32], qj[31:0],
                       OFF_W'(qo), rj[63:32], rj[31:0], OFF_W'(ro), rc);
   endfunction

   // Send one chunk item; bursts of random length with random gaps between
   task automatic send_chunk(input chunk_type c);
      rsp_item_type res;
      bit has_res;
      bit ignored;
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_if.first_chunk   <= c.first_chunk;
      req_if.last_chunk    <= c.last_chunk;
      req_if.align_length  <= c.align_length;
      req_if.chunk_bases   <= c.chunk_bases;
      req_if.query_word_lo <= c.q_lo;
      req_if.query_word_hi <= c.q_hi;
      req_if.query_offset  <= c.q_off;
      req_if.ref_word_lo   <= c.r_lo;
      req_if.ref_word_hi   <= c.r_hi;
      req_if.ref_offset    <= c.r_off;
      req_if.strand        <= c.strand;
      req_if.valid         <= 1'b1;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      burst_left--;
      items_sent++;
      predict_chunk(c, res, has_res, ignored);
      if (has_res) pending_results = {pending_results, res};
      if (!ignored) live_items++;
   endtask

   // Drain everything in flight, then let the pipeline go quiet
   task automatic settle_pipeline();
      req_if.valid <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (addr == SIM_ADDR) sim_setting = data[SIM_W-1:0];
      csr_writes++;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read(input logic [CSR_ADDR_W-1:0] addr,
                           output logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      data = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_similarity_readback();
      logic [CSR_DATA_W-1:0] rd;
      csr_read(SIM_ADDR, rd);
      if (rd !== CSR_DATA_W'(sim_setting))
         report_mismatch("similarity readback", int'(rd), int'(sim_setting));
   endtask

   task automatic set_similarity(input logic [CSR_DATA_W-1:0] data);
      settle_pipeline();
      csr_write(SIM_ADDR, data);
      check_similarity_readback();
   endtask

   // One alignment, well formed or broken on purpose
   task automatic send_alignment(input bit broken);
      int alen;
      int eff;
      int left;
      int nb;
      int nbf;
      int nchunks;
      int mut;
      int flavor;
      int cut;
      int pick;
      bit rc;
      bit lastf;
      bit firstf;
      int mut_rates[7] = '{0, 0, 10, 30, 60, 150, 500};
      pick = $urandom_range(0, 99);
      if (pick < 70)      alen = $urandom_range(1, 64);
      else if (pick < 90) alen = $urandom_range(65, 300);
      else if (pick < 97) alen = $urandom_range(301, 1024);
      else                alen = $urandom_range(1025, 2047);
      eff     = (alen > 1024) ? 1024 : alen;
      nchunks = (eff + 15) / 16;
      rc      = $urandom_range(0, 1);
      mut     = mut_rates[$urandom_range(0, 6)];
      flavor  = broken ? $urandom_range(0, 3) : -1;
      cut     = $urandom_range(0, nchunks - 1);
      left    = eff;
      for (int k = 0; k < nchunks; k++) begin
         nb = (left > 16) ? 16 : left;
         left -= nb;
         lastf  = (k == nchunks - 1);
         firstf = (k == 0) && (flavor != 3);   // flavor 3: no start mark
         nbf = nb;
         if (flavor == 2 && nb == 16) nbf = $urandom_range(16, 31);
         if (flavor == 0 && k == cut) lastf = 1'b0;
         send_chunk(make_chunk(firstf, lastf, (k == 0) ? alen : $urandom_range(0, 2047),
                               nbf, rc, mut));
         if (flavor == 0 && k == cut) break;
      end
      // stray chunks after the end, mostly dropped
      if (flavor == 1) begin
         repeat ($urandom_range(1, 3))
            send_chunk(make_chunk(1'b0, $urandom_range(0, 1), $urandom_range(0, 2047),
                                  $urandom_range(0, 31), rc, mut));
      end
   endtask

   task automatic send_noise();
      send_chunk(raw_chunk($urandom_range(0, 1), $urandom_range(0, 1), ALEN_W'($urandom),
                           NB_W'($urandom), $urandom, $urandom, OFF_W'($urandom),
                           $urandom, $urandom, OFF_W'($urandom), $urandom_range(0, 1)));
   endtask

   // ---- directed tests ----

   task automatic test_reset_value();
      if (sim_setting !== SIM_RESET)
         report_mismatch("bench reset similarity", sim_setting, SIM_RESET);
      check_similarity_readback();
   endtask

   task automatic test_headless_chunks();
      // tally and pass mark are both zero out of reset: a clean last chunk gives (0, kept)
      send_chunk(make_chunk(1'b0, 1'b1, 5, 16, 1'b0, 0));
      // after a last chunk, non-first chunks are dropped
      send_chunk(make_chunk(1'b0, 1'b0, 5, 16, 1'b0, 1000));
   endtask

   task automatic test_single_chunk_alignments();
      send_chunk(make_chunk(1'b1, 1'b1, 16, 16, 1'b0, 0));
      send_chunk(make_chunk(1'b1, 1'b1, 16, 16, 1'b0, 1000));
      // length above the maximum is clamped
      send_chunk(make_chunk(1'b1, 1'b1, 2047, 16, 1'b0, 0));
      // oversized chunk compares 16 bases
      send_chunk(make_chunk(1'b1, 1'b1, 16, 31, 1'b0, 0));
      // empty chunk finds no mismatches
      send_chunk(make_chunk(1'b1, 1'b1, 1, 0, 1'b0, 1000));
      send_chunk(make_chunk(1'b1, 1'b1, 1, 1, 1'b0, 1000));
   endtask

   task automatic test_midway_rejection();
      send_chunk(make_chunk(1'b1, 1'b0, 48, 16, 1'b0, 0));
      send_chunk(make_chunk(1'b0, 1'b0, 0, 16, 1'b0, 1000));   // rejects at once
      send_chunk(make_chunk(1'b0, 1'b1, 0, 16, 1'b0, 0));      // dropped
      // three-chunk alignment on the reverse strand that survives
      send_chunk(make_chunk(1'b1, 1'b0, 40, 16, 1'b1, 0));
      send_chunk(make_chunk(1'b0, 1'b0, 2047, 16, 1'b1, 0));
      send_chunk(make_chunk(1'b0, 1'b1, 0, 8, 1'b1, 0));
   endtask

   task automatic test_word_extremes();
      send_chunk(raw_chunk(1'b1, 1'b1, 11'd16, 5'd16, '1, '1, 4'd15, '0, '0, 4'd0, 1'b0));
      send_chunk(raw_chunk(1'b1, 1'b1, 11'd16, 5'd16, '1, '1, 4'd15, '1, '1, 4'd15, 1'b0));
      // complement of all-zero reference is all-ones
      send_chunk(raw_chunk(1'b1, 1'b1, 11'd16, 5'd16, '1, '1, 4'd0, '0, '0, 4'd15, 1'b1));
      send_chunk(raw_chunk(1'b1, 1'b1, 11'd16, 5'd16, '0, '0, 4'd15, '0, '0, 4'd0, 1'b1));
   endtask

   task automatic test_similarity_extremes();
      // zero similarity: nothing is rejected, even a full mismatch
      set_similarity(32'd0);
      send_chunk(make_chunk(1'b1, 1'b1, 16, 16, 1'b0, 1000));
      // full similarity: a single chunk with mismatches rejects
      set_similarity(32'(Q16_ONE));
      send_chunk(make_chunk(1'b1, 1'b1, 16, 16, 1'b0, 0));
      send_chunk(make_chunk(1'b1, 0, 32, 16, 1'b0, 0));
      send_chunk(make_chunk(1'b0, 1'b1, 0, 16, 1'b0, 1000));
      // above one is treated as one; upper write bits are not stored
      set_similarity(32'hFFFF_FFFF);
      send_chunk(make_chunk(1'b1, 1'b1, 16, 16, 1'b0, 0));
   endtask

   task automatic test_random_traffic(input logic [CSR_DATA_W-1:0] sim_word);
      int goal;
      set_similarity(sim_word);
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) begin
         if ($urandom_range(0, 99) < 8) send_noise();
         else send_alignment($urandom_range(0, 99) < 12);
      end
   endtask

   // ---- result checking ----
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result, match_count", rsp_if.match_count, -1);
         end else begin
            want = pending_results.pop_front();
            if (rsp_if.match_count !== want.match_count)
               report_mismatch("match_count", rsp_if.match_count, want.match_count);
            if (rsp_if.rejected !== want.rejected)
               report_mismatch("rejected", rsp_if.rejected, want.rejected);
            results_checked++;
            if (want.rejected) rejects_seen++;
         end
      end
   end

   // ---- receiver: stall pattern switches among a few modes ----
   initial begin
      rsp_if.ready = 1'b0;
      rx_left = 0;
      rx_tick = 0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else begin
            if (rx_left == 0) begin
               rx_mode = rx_mode_type'($urandom_range(0, 3));
               rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            rx_tick++;
            case (rx_mode)
               RX_OPEN:     rsp_if.ready <= 1'b1;
               RX_SPOTTY:   rsp_if.ready <= ($urandom_range(0, 3) != 0);
               RX_PERIODIC: rsp_if.ready <= ((rx_tick % 7) >= 4);
               default:     rsp_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // ---- watchdog: quiet cycles with no handshake of any kind ----
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (psel && penable))
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: no handshake for %0d cycles, %0d results pending",
               WATCHDOG_LIMIT, pending_results.size());
      $display("Regression FAIL");
      $finish;
   end

   // ---- main sequence ----
   initial begin
      reset   = 1'b1;
      clock   = 1'b0;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      req_if.valid         = 1'b0;
      req_if.first_chunk   = 1'b0;
      req_if.last_chunk    = 1'b0;
      req_if.align_length  = '0;
      req_if.chunk_bases   = '0;
      req_if.query_word_lo = '0;
      req_if.query_word_hi = '0;
      req_if.query_offset  = '0;
      req_if.ref_word_lo   = '0;
      req_if.ref_word_hi   = '0;
      req_if.ref_offset    = '0;
      req_if.strand        = 1'b0;
      sim_setting = SIM_RESET;
      match_tally = '0;
      pass_mark   = '0;
      dropping    = 1'b0;
      mismatches  = 0;
      items_sent  = 0;
      live_items  = 0;
      results_checked = 0;
      rejects_seen    = 0;
      csr_writes  = 0;
      burst_left  = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_value();
      test_headless_chunks();
      test_single_chunk_alignments();
      test_midway_rejection();
      test_word_extremes();
      test_similarity_extremes();

      test_random_traffic(32'(SIM_RESET));
      test_random_traffic(32'($urandom_range(45000, 65535)));
      test_random_traffic(32'(Q16_ONE));
      test_random_traffic(32'd0);
      test_random_traffic($urandom | 32'h0001_FFFF);

      settle_pipeline();
      if (pending_results.size() != 0)
         report_mismatch("results never delivered", 0, pending_results.size());

      $display("Covered %0d chunk items (%0d compared), %0d results checked, %0d rejections",
               items_sent, live_items, results_checked, rejects_seen);
      $display("Similarity register written %0d times incl. 0, one and above one; %0d mismatches",
               csr_writes, mismatches);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
